// ===== rtl/core/pbpl_pkg.sv =====
`default_nettype none

package pbpl_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SampW  = 16;
  localparam int unsigned LevelW = 14;
  localparam int unsigned RbW    = 4;
  localparam int unsigned RangeW = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [SampW-1:0] SignFlip = 16'h8000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgWideSamples = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStereo      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPwmRange    = 2'd2;

  typedef struct packed {
    logic             wide_samples;
    logic             stereo;
    logic [RbW-1:0]   res_bits;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        byte_phase;
    logic [ByteW-1:0]  low_byte_hold;
    logic [LevelW-1:0] first_channel_level;
  } frame_state_t;

  // resolution bits from the pwm period count
  function automatic logic [RbW-1:0] res_bits_of(input logic [RangeW-1:0] range);
    logic [RbW-1:0] rb;
    rb = RbW'(1);
    for (int i = 2; i < RangeW - 1; i++) begin
      if (range[i]) begin
        rb = RbW'(i);
      end
    end
    if (range[RangeW-1]) begin
      rb = '0;
    end
    return rb;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pbpl_step.sv =====
`default_nettype none

module pbpl_step (
  input  wire  pbpl_pkg::cfg_t                   cfg_i,
  input  wire  pbpl_pkg::frame_state_t           state_i,
  input  wire  logic [pbpl_pkg::ByteW-1:0]       data_byte_i,
  input  wire  logic                             last_byte_i,
  output pbpl_pkg::frame_state_t                 state_o,
  output logic                                   emit_o,
  output logic [pbpl_pkg::LevelW-1:0]            left_o,
  output logic [pbpl_pkg::LevelW-1:0]            right_o
);

  logic [pbpl_pkg::SampW-1:0]  sample;
  logic [4:0]                  shamt;
  logic [pbpl_pkg::SampW-1:0]  shifted;
  logic [pbpl_pkg::LevelW-1:0] level;
  logic                        have_sample;
  logic                        channel;
  logic [1:0]                  phase_inc;

  // 8-bit samples sit in the top byte so one right shift covers both widths
  always_comb begin
    if (cfg_i.wide_samples) begin
      sample = {data_byte_i, state_i.low_byte_hold} + pbpl_pkg::SignFlip;
    end else begin
      sample = {data_byte_i, 8'h00};
    end
    shamt   = 5'd16 - {1'b0, cfg_i.res_bits};
    shifted = sample >> shamt;
    level   = shifted[pbpl_pkg::LevelW-1:0];
  end

  always_comb begin
    phase_inc   = state_i.byte_phase + 2'd1;
    state_o     = state_i;
    emit_o      = 1'b0;
    left_o      = level;
    right_o     = level;
    have_sample = 1'b1;
    channel     = 1'b0;

    if (cfg_i.wide_samples) begin
      channel = state_i.byte_phase[1];
      if (!state_i.byte_phase[0]) begin
        state_o.low_byte_hold = data_byte_i;
        state_o.byte_phase    = phase_inc;
        have_sample           = 1'b0;
      end
    end else begin
      channel = |state_i.byte_phase;
    end

    if (have_sample) begin
      if (!cfg_i.stereo) begin
        emit_o             = 1'b1;
        state_o.byte_phase = 2'd0;
      end else if (channel) begin
        emit_o             = 1'b1;
        left_o             = state_i.first_channel_level;
        state_o.byte_phase = 2'd0;
      end else begin
        state_o.first_channel_level = level;
        state_o.byte_phase          = phase_inc;
      end
    end

    if (last_byte_i) begin
      state_o.byte_phase = 2'd0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pcm_bytes_to_pwm_levels.sv =====
// PCM byte stream to PWM level pairs. One raw byte is taken per beat on the
// input channel (valid/stall) and one left/right level pair is delivered per
// completed frame on the output channel: every byte in 8-bit mono, every
// second byte in 8-bit stereo or 16-bit mono, every fourth in 16-bit stereo.
// The block sustains one byte per clock except while a byte that finishes a
// frame waits for the output register; a byte goes into the input register,
// then its result into the output register. Bytes that finish no frame keep
// flowing while a result waits in the output register; a byte that finishes
// a frame waits only for the output register to free. Configuration is a
// plain write port (index 0: wide_samples, 1: stereo, 2: pwm_range); the
// resolution is derived from pwm_range when it is written. A byte with
// last_byte set drops any partial frame after it is used.
`default_nettype none

module pcm_bytes_to_pwm_levels (
  input  wire  logic                                clk_i,
  input  wire  logic                                rst_ni,
  // configuration writes
  input  wire  logic                                cfg_we_i,
  input  wire  logic [pbpl_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire  logic [pbpl_pkg::RangeW-1:0]         cfg_data_i,
  // byte input channel
  input  wire  logic                                in_valid_i,
  output logic                                      in_stall_o,
  input  wire  logic [pbpl_pkg::ByteW-1:0]          data_byte_i,
  input  wire  logic                                last_byte_i,
  // level output channel
  output logic                                      out_valid_o,
  input  wire  logic                                out_stall_i,
  output logic [pbpl_pkg::LevelW-1:0]               left_level_o,
  output logic [pbpl_pkg::LevelW-1:0]               right_level_o
);

  pbpl_pkg::cfg_t         cfg_q;
  pbpl_pkg::frame_state_t state_q, state_d;

  // input register
  logic                         in_vld_q;
  logic [pbpl_pkg::ByteW-1:0]   byte_q;
  logic                         last_q;

  // output register
  logic                         out_vld_q;
  logic [pbpl_pkg::LevelW-1:0]  left_q, right_q;

  logic                         emit;
  logic [pbpl_pkg::LevelW-1:0]  left_d, right_d;
  logic                         out_free;
  logic                         advance;
  logic                         accept;

  // configuration registers, the range is kept as resolution bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wide_samples <= 1'b0;
      cfg_q.stereo       <= 1'b0;
      cfg_q.res_bits     <= pbpl_pkg::res_bits_of('0);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pbpl_pkg::CfgWideSamples: cfg_q.wide_samples <= cfg_data_i[0];
        pbpl_pkg::CfgStereo:      cfg_q.stereo       <= cfg_data_i[0];
        pbpl_pkg::CfgPwmRange:    cfg_q.res_bits     <= pbpl_pkg::res_bits_of(cfg_data_i);
        default: ;
      endcase
    end
  end

  // frame assembly and scaling for the byte in the input register
  pbpl_step u_step (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .data_byte_i (byte_q),
    .last_byte_i (last_q),
    .state_o     (state_d),
    .emit_o      (emit),
    .left_o      (left_d),
    .right_o     (right_d)
  );

  // the output register frees when empty or when its beat is taken
  assign out_free   = !out_vld_q || !out_stall_i;
  // a byte that completes no frame never waits for the output side
  assign advance    = in_vld_q && (!emit || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  // frame state moves only when the held byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign left_level_o  = left_q;
  assign right_level_o = right_q;

endmodule

`default_nettype wire

// ===== test/pwm_level_checker.sv =====
`timescale 1ns / 100ps

module pwm_level_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pbpl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pbpl_pkg::RangeW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [pbpl_pkg::ByteW-1:0]    data_byte_i,
  input  logic                          last_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [pbpl_pkg::LevelW-1:0]   left_level_i,
  input  logic [pbpl_pkg::LevelW-1:0]   right_level_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   pending_o,
  output int unsigned                   pairs_o
);
  import pbpl_pkg::*;

  typedef struct packed {
    logic [LevelW-1:0] left;
    logic [LevelW-1:0] right;
  } level_pair_t;

  level_pair_t       due_pairs[$];
  logic              wide_q;
  logic              stereo_q;
  logic [RangeW-1:0] period_q;
  logic [1:0]        phase_q;
  logic [ByteW-1:0]  low_q;
  logic [LevelW-1:0] first_q;
  int unsigned       errors;
  int unsigned       pairs;

  // one less than the smallest exponent from 2 whose power of two exceeds the period, zero if none below 16
  function automatic logic [RbW-1:0] resolution_of(input logic [RangeW-1:0] period);
    for (int n = 2; n < 16; n++) begin
      if ({1'b0, period} < (17'd1 << n)) begin
        return RbW'(n - 1);
      end
    end
    return '0;
  endfunction

  function automatic logic [LevelW-1:0] scale_to_range(input logic [SampW-1:0] s,
                                                       input int unsigned bits);
    int unsigned rb;
    logic [31:0] shifted;
    rb = 32'(resolution_of(period_q));
    if (bits >= rb) begin
      shifted = {16'd0, s} >> (bits - rb);
    end else begin
      shifted = {16'd0, s} << (rb - bits);
    end
    return shifted[LevelW-1:0];
  endfunction

  // frame assembly for one accepted byte
  task automatic take_byte(input logic [ByteW-1:0] b, input logic is_last);
    logic [1:0]        ph;
    logic              got;
    logic [1:0]        chan;
    logic [LevelW-1:0] lvl;
    logic [SampW-1:0]  s;
    ph   = phase_q;
    got  = 1'b0;
    chan = '0;
    lvl  = '0;
    if (wide_q) begin
      if (!ph[0]) begin
        low_q   = b;
        phase_q = ph + 2'd1;
      end else begin
        s    = {b, low_q} + SignFlip;
        lvl  = scale_to_range(s, 16);
        chan = ph >> 1;
        got  = 1'b1;
      end
    end else begin
      lvl  = scale_to_range({8'd0, b}, 8);
      chan = ph;
      got  = 1'b1;
    end
    if (got) begin
      if (!stereo_q) begin
        due_pairs.push_back('{left: lvl, right: lvl});
        phase_q = '0;
      end else if (chan != 2'd0) begin
        due_pairs.push_back('{left: first_q, right: lvl});
        phase_q = '0;
      end else begin
        first_q = lvl;
        phase_q = ph + 2'd1;
      end
    end
    if (is_last) begin
      phase_q = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    level_pair_t want;
    if (!rst_ni) begin
      due_pairs.delete();
      wide_q   = 1'b0;
      stereo_q = 1'b0;
      period_q = '0;
      phase_q  = '0;
      low_q    = '0;
      first_q  = '0;
      errors   = 0;
      pairs    = 0;
    end else begin
      // results leave before the byte of this edge can add one
      if (out_valid_i && !out_stall_i) begin
        if (due_pairs.size() == 0) begin
          errors++;
          $display("%0t: level pair (%0d, %0d) with none expected", $time,
                   left_level_i, right_level_i);
        end else begin
          want = due_pairs.pop_front();
          pairs++;
          if (left_level_i !== want.left) begin
            errors++;
            $display("%0t: left_level expected %0d, got %0d", $time, want.left,
                     left_level_i);
          end
          if (right_level_i !== want.right) begin
            errors++;
            $display("%0t: right_level expected %0d, got %0d", $time, want.right,
                     right_level_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        take_byte(data_byte_i, last_byte_i);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgWideSamples: wide_q = cfg_data_i[0];
          CfgStereo:      stereo_q = cfg_data_i[0];
          CfgPwmRange:    period_q = cfg_data_i;
          default: ;
        endcase
      end
    end
    mismatches_o <= errors;
    pending_o    <= due_pairs.size();
    pairs_o      <= pairs;
  end

endmodule

// ===== test/tb_pcm_bytes_to_pwm_levels.sv =====
`timescale 1ns / 100ps

module tb_pcm_bytes_to_pwm_levels;
  import pbpl_pkg::*;

  // stimulus stops after the chunk in which this many bytes have gone in
  localparam int unsigned ItemTarget   = 1950;
  // idle cycles after the last pair before a register write
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles  = 8;
  // longest correct quiet stretch is a source gap plus a receiver stall
  localparam int unsigned StallLimit   = 2000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [RangeW-1:0]   cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [ByteW-1:0]    data_byte_i = '0;
  logic                last_byte_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [LevelW-1:0]   left_level_o;
  logic [LevelW-1:0]   right_level_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned pairs;

  // bookkeeping for the summary
  int unsigned bytes_sent = 0;
  int unsigned lasts_sent = 0;
  int unsigned settings   = 0;

  // current register values, used to shape well-formed buffers
  logic cur_wide   = 1'b0;
  logic cur_stereo = 1'b0;

  // stretches with no idling on either side
  bit src_calm = 1'b0;
  bit snk_calm = 1'b0;

  wire in_beat  = in_valid_i && !in_stall_o;
  wire out_beat = out_valid_o && !out_stall_i;

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  pcm_bytes_to_pwm_levels dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_level_o  (left_level_o),
    .right_level_o (right_level_o)
  );

  pwm_level_checker levels (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_level_i  (left_level_o),
    .right_level_i (right_level_o),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .pairs_o       (pairs)
  );

  // one byte beat, preceded by a random gap; payload holds while stalled
  task automatic send_byte(input logic [ByteW-1:0] value, input logic is_last);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= value;
    last_byte_i <= is_last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    if (is_last) begin
      lasts_sent++;
    end
  endtask

  // drop valid, wait for every pair to come out, then let a byte that
  // finishes no frame drain from the input register
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // all three registers, one write per clock, only with the block idle
  task automatic write_config(input logic wide, input logic two_ch,
                              input logic [RangeW-1:0] period);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgWideSamples;
    cfg_data_i <= RangeW'(wide);
    @(posedge clk_i);
    cfg_idx_i  <= CfgStereo;
    cfg_data_i <= RangeW'(two_ch);
    @(posedge clk_i);
    cfg_idx_i  <= CfgPwmRange;
    cfg_data_i <= period;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_wide   = wide;
    cur_stereo = two_ch;
    settings++;
  endtask

  // period that lands on every resolution, extremes weighted up
  function automatic logic [RangeW-1:0] pick_period();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'h4000;
      default: return RangeW'($urandom_range(0, 65535) >> $urandom_range(0, 16));
    endcase
  endfunction

  // whole frames closed by a last byte; some buffers cut short mid-frame,
  // a few with last set on stray bytes inside
  task automatic send_buffer();
    int unsigned frame_len;
    int unsigned len;
    bit noisy;
    frame_len = (cur_wide ? 2 : 1) * (cur_stereo ? 2 : 1);
    len = frame_len * $urandom_range(1, 8);
    if ($urandom_range(0, 4) == 0) begin
      len = $urandom_range(1, len);
    end
    noisy = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      send_byte(ByteW'($urandom),
                (i == len - 1) || (noisy && $urandom_range(0, 3) == 0));
    end
  endtask

  // receiver: random stall before each pair, then open until a beat lands
  initial begin : sink
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = snk_calm ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // watchdog on cycles with no beat on any port
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (in_beat || out_beat || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no beat for %0d cycles, %0d pairs outstanding", $time, StallLimit,
             pending);
    $display("tb_pcm_bytes_to_pwm_levels: FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned chunk_end;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 8-bit mono at one-bit resolution, byte extremes
    write_config(1'b0, 1'b0, 16'h0000);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);

    // top bit of the period set gives zero resolution
    write_config(1'b0, 1'b0, 16'hFFFF);
    send_byte(8'hFF, 1'b0);

    // 8-bit stereo at 14 bits, then a left sample dropped by last
    write_config(1'b0, 1'b1, 16'h4000);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h12, 1'b1);

    // 16-bit mono, sign flip at both ends of the signed range
    write_config(1'b1, 1'b0, 16'h7FFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    // low byte only, frame left open
    send_byte(8'h34, 1'b0);

    // registers change with a frame half done, byte read under the new mode
    write_config(1'b0, 1'b1, 16'h8000);
    send_byte(8'hAA, 1'b0);

    // 16-bit stereo: full frame, a frame cut by last, a frame closed by last
    write_config(1'b1, 1'b1, 16'h00FF);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);

    // random register settings, each followed by a run of buffers
    while (bytes_sent < ItemTarget) begin
      write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_period());
      src_calm  = ($urandom_range(0, 3) == 0);
      snk_calm  = ($urandom_range(0, 3) == 0);
      chunk_end = bytes_sent + $urandom_range(30, 90);
      while (bytes_sent < chunk_end) begin
        send_buffer();
      end
      // sometimes leave a frame open across the next register change
      if ($urandom_range(0, 2) == 0) begin
        send_byte(ByteW'($urandom), 1'b0);
      end
      src_calm = 1'b0;
      snk_calm = 1'b0;
    end

    // drain, then wait DrainCycles more for anything unexpected
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d bytes (%0d marked last) under %0d register settings",
             bytes_sent, lasts_sent, settings);
    $display("%0d level pairs compared, %0d mismatches", pairs, mismatches);
    if (mismatches == 0) begin
      $display("tb_pcm_bytes_to_pwm_levels: PASS");
    end else begin
      $display("tb_pcm_bytes_to_pwm_levels: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pbpl_pkg.sv
rtl/core/pbpl_step.sv
rtl/core/pcm_bytes_to_pwm_levels.sv
test/pwm_level_checker.sv
test/tb_pcm_bytes_to_pwm_levels.sv
